// File: hdl/fxalu_pkg.sv
// Shared package for the Q24.8 fixed-point ALU: sizes, opcodes, item classes
// and the queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fxalu_pkg;
	localparam int FRAC_BITS  = 8;
	localparam int DATA_WIDTH = 32;
	localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
	localparam int CNT_W      = $clog2(NUM_W + 1);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
		OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
	} op_t;

	typedef enum logic [1:0] {
		CL_SIMPLE, CL_MUL, CL_DIV, CL_DIVZ
	} cls_t;

	typedef struct packed {
		op_t                           op;
		cls_t                          cls;
		logic signed [DATA_WIDTH-1:0]  a;
		logic signed [DATA_WIDTH-1:0]  b;
	} item_t;
endpackage
`default_nettype wire

// File: hdl/fxalu_front.sv
// Front end: classifies an incoming beat into simple, multiply, divide or
// divide-by-zero work and forms the queue entry. Depends on fxalu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxalu_front import fxalu_pkg::*; (
	input  wire logic [3:0]            op,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output item_t                      item
);
	op_t op_e;
	cls_t cls;

	assign op_e = op_t'(op);

	always_comb begin
		case (op_e)
			OP_MUL:  cls = CL_MUL;
			OP_DIV:  cls = (operand_b == '0) ? CL_DIVZ : CL_DIV;
			default: cls = CL_SIMPLE;
		endcase
	end

	assign item.op  = op_e;
	assign item.cls = cls;
	assign item.a   = operand_a;
	assign item.b   = operand_b;
endmodule
`default_nettype wire

// File: hdl/fxalu_queue.sv
// Short in-order queue of classified items between front and back end.
// Depends on fxalu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxalu_queue import fxalu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output logic       empty,
	output logic       full
);
	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/fxalu_div.sv
// Radix-2 restoring divider for (|a| << FRAC_BITS) / |b|, one quotient bit
// per cycle, sign applied at the end. Depends on fxalu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxalu_div import fxalu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] a,
	input  wire logic [DATA_WIDTH-1:0] b,
	output logic                       busy,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      quotient
);
	logic [DATA_WIDTH-1:0] rem_q, den_q, mag_a, mag_b, q_mag;
	logic [NUM_W-1:0]      num_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q, done_q, neg_q;
	logic [DATA_WIDTH:0]   shifted, diff;
	logic                  ge;

	assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = !diff[DATA_WIDTH];

	assign busy     = busy_q;
	assign done     = done_q;
	assign q_mag    = num_q[DATA_WIDTH-1:0];
	assign quotient = neg_q ? (~q_mag + 1'b1) : q_mag;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= NUM_W'(mag_a) << FRAC_BITS;
			den_q <= mag_b;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/fxalu_back.sv
// Back end: executes queued items in order. Simple ops, multiply and divide
// by zero run in two stages; other divides in fxalu_div. Depends on fxalu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxalu_back import fxalu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire item_t              head,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    done,
	output logic [DATA_WIDTH-1:0]   result_value,
	output logic                    compare_true,
	output logic                    divide_error
);
	logic signed [DATA_WIDTH-1:0] a, b;
	logic [DATA_WIDTH-1:0]        mag_a, mag_b, res, mul_q, mul_v, div_q;
	logic                         cmp, lt_ab, lt_ba, div_busy, div_done, div_start;
	logic [2*DATA_WIDTH-1:0]      prod;

	logic                         valid_s1, is_mul_s1, neg_s1, cmp_s1, err_s1;
	logic [DATA_WIDTH-1:0]        res_s1;
	logic [2*DATA_WIDTH-1:0]      prod_s1;

	logic                         valid_s2, cmp_s2, err_s2;
	logic [DATA_WIDTH-1:0]        res_s2;

	assign a     = head.a;
	assign b     = head.b;
	assign pop   = !empty && !div_busy;
	assign div_start = pop && (head.cls == CL_DIV);

	assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
	assign prod  = mag_a * mag_b;
	assign lt_ab = a < b;
	assign lt_ba = b < a;

	always_comb begin
		res = '0;
		cmp = 1'b0;
		case (head.op)
			OP_ADD:      res = a + b;
			OP_SUB:      res = a - b;
			OP_GT:       cmp = lt_ba;
			OP_LT:       cmp = lt_ab;
			OP_GE:       cmp = !lt_ab;
			OP_LE:       cmp = !lt_ba;
			OP_EQ:       cmp = (a == b);
			OP_NE:       cmp = (a != b);
			OP_MIN:      res = lt_ba ? b : a;
			OP_MAX:      res = lt_ab ? b : a;
			OP_INC:      res = a + 1'b1;
			OP_DEC:      res = a - 1'b1;
			OP_TO_INT:   res = a >>> FRAC_BITS;
			OP_FROM_INT: res = a << FRAC_BITS;
			default:     res = '0;
		endcase
	end

	fxalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.a        (head.a),
		.b        (head.b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1    <= res;
			cmp_s1    <= cmp;
			err_s1    <= (head.cls == CL_DIVZ);
			is_mul_s1 <= (head.cls == CL_MUL);
			neg_s1    <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			prod_s1   <= prod;
		end
	end

	assign mul_q = prod_s1[FRAC_BITS +: DATA_WIDTH];
	assign mul_v = neg_s1 ? (~mul_q + 1'b1) : mul_q;

	always_ff @(posedge clk) begin
		if (div_done) begin
			res_s2 <= div_q;
			cmp_s2 <= 1'b0;
			err_s2 <= 1'b0;
		end else if (valid_s1) begin
			res_s2 <= is_mul_s1 ? mul_v : res_s1;
			cmp_s2 <= cmp_s1;
			err_s2 <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= pop && (head.cls != CL_DIV);
			valid_s2 <= valid_s1 || div_done;
		end
	end

	assign done         = valid_s2;
	assign result_value = res_s2;
	assign compare_true = cmp_s2;
	assign divide_error = err_s2;
endmodule
`default_nettype wire

// File: hdl/fixed_point_q24_8_alu.sv
// Top level of the signed Q24.8 fixed-point ALU: front end, item queue and
// back end. Depends on fxalu_pkg, fxalu_front, fxalu_queue and fxalu_back.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------------
//   command   start / busy         op, operand_a, operand_b
//   result    done (one-cycle)     result_value, compare_true, divide_error
//
// A command beat is taken at a rising edge with start high and busy low; it
// goes into a four-entry queue. Busy is high only while that queue is full.
// All operations except a divide with a nonzero divisor leave the queue at
// one per cycle while the divider is idle, pass through the s1 and s2
// registers to the result ports, and so stream at one beat per cycle.
// A divide with a nonzero divisor runs in the one-bit-per-cycle divider;
// no later item leaves the queue while it is busy. Results appear in
// command order, each for exactly one cycle with done high; the receiver
// cannot stall. Reset clears the queue, valid flags and divider control.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu import fxalu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [3:0]            op,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      result_value,
	output logic                       compare_true,
	output logic                       divide_error
);
	item_t in_item, head;
	logic  push, pop, empty, full;

	// The front end only labels the command; the queue does the decoupling.
	fxalu_front u_front (
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.item      (in_item)
	);

	assign busy = full;
	assign push = start && !full;

	fxalu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// The back end pops whenever the queue is not empty and the divider is not busy.
	fxalu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.done         (done),
		.result_value (result_value),
		.compare_true (compare_true),
		.divide_error (divide_error)
	);
endmodule
`default_nettype wire
